FILE: rtl/mbb_pkg.sv
// Shared types, register indexes and mask weight tables for the masked boundary blend unit.
package mbb_pkg;

  localparam int unsigned PixPortBits = 12;
  localparam int unsigned WeightBits = 7;
  localparam logic [WeightBits-1:0] WeightOne = 7'd64;
  localparam logic [5:0] BlendRound = 6'd32;

  typedef logic [2:0] reg_index_t;
  localparam reg_index_t RegSplitVertical = 3'd0;
  localparam reg_index_t RegMaskLengthCode = 3'd1;
  localparam reg_index_t RegChromaMask = 3'd2;
  localparam reg_index_t RegBlendOffset = 3'd3;
  localparam reg_index_t RegRegionWidth = 3'd4;
  localparam reg_index_t RegRegionHeight = 3'd5;

  localparam logic [1:0] LenCode8 = 2'd0;
  localparam logic [1:0] LenCode16 = 2'd1;

  typedef logic [WeightBits-1:0] weight_t;

  // One beat held between the position stage and the blend stage.
  typedef struct packed {
    logic [PixPortBits-1:0] pixel_first;
    logic [PixPortBits-1:0] pixel_second;
    weight_t                weight;
    logic                   last;
  } stage_t;

  function automatic weight_t mask_weight(input logic [1:0] len_code, input logic chroma,
                                          input logic [4:0] d);
    weight_t w;
    w = '0;
    if (len_code == LenCode8) begin
      case (d[2:0])
        3'd0: w = 7'd64;
        3'd1: w = 7'd64;
        3'd2: w = 7'd62;
        3'd3: w = 7'd52;
        3'd4: w = 7'd12;
        3'd5: w = 7'd2;
        default: w = 7'd0;
      endcase
    end else if (len_code == LenCode16) begin
      if (chroma) begin
        case (d[3:0])
          4'd0, 4'd1, 4'd2, 4'd3: w = 7'd64;
          4'd4: w = 7'd61;
          4'd5: w = 7'd53;
          4'd6: w = 7'd45;
          4'd7: w = 7'd36;
          4'd8: w = 7'd28;
          4'd9: w = 7'd19;
          4'd10: w = 7'd11;
          4'd11: w = 7'd3;
          default: w = 7'd0;
        endcase
      end else begin
        case (d[3:0])
          4'd0: w = 7'd63;
          4'd1: w = 7'd62;
          4'd2: w = 7'd60;
          4'd3: w = 7'd58;
          4'd4: w = 7'd55;
          4'd5: w = 7'd50;
          4'd6: w = 7'd43;
          4'd7: w = 7'd36;
          4'd8: w = 7'd28;
          4'd9: w = 7'd21;
          4'd10: w = 7'd14;
          4'd11: w = 7'd9;
          4'd12: w = 7'd6;
          4'd13: w = 7'd4;
          4'd14: w = 7'd2;
          default: w = 7'd1;
        endcase
      end
    end else begin
      if (chroma) begin
        case (d)
          5'd12: w = 7'd60;
          5'd13: w = 7'd54;
          5'd14: w = 7'd46;
          5'd15: w = 7'd36;
          5'd16: w = 7'd28;
          5'd17: w = 7'd18;
          5'd18: w = 7'd10;
          5'd19: w = 7'd4;
          default: w = (d < 5'd12) ? 7'd64 : 7'd0;
        endcase
      end else begin
        case (d)
          5'd10: w = 7'd63;
          5'd11: w = 7'd61;
          5'd12: w = 7'd57;
          5'd13: w = 7'd52;
          5'd14: w = 7'd45;
          5'd15: w = 7'd36;
          5'd16: w = 7'd28;
          5'd17: w = 7'd19;
          5'd18: w = 7'd12;
          5'd19: w = 7'd7;
          5'd20: w = 7'd3;
          5'd21: w = 7'd1;
          default: w = (d < 5'd10) ? 7'd64 : 7'd0;
        endcase
      end
    end
    return w;
  endfunction

endpackage

FILE: rtl/mbb_blend.sv
// Weighted blend of two pixels with a registered result stage and output handshake.
module mbb_blend #(
  parameter int unsigned PIXEL_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  mbb_pkg::stage_t                     in_beat,
  output logic                                in_ready,
  output logic                                out_valid,
  output logic [mbb_pkg::PixPortBits-1:0]     out_pixel,
  output logic                                out_last,
  input  logic                                out_ready
);

  localparam int unsigned PW = (PIXEL_BITS < mbb_pkg::PixPortBits) ?
                               PIXEL_BITS : mbb_pkg::PixPortBits;
  localparam int unsigned SW = PW + mbb_pkg::WeightBits + 1;

  logic [PW-1:0]                  pix_a;
  logic [PW-1:0]                  pix_b;
  logic [mbb_pkg::WeightBits-1:0] weight_inv;
  logic [SW-1:0]                  blend_sum;
  logic [PW-1:0]                  pixel_next;
  logic [PW-1:0]                  pixel_q;
  logic                           last_q;
  logic                           valid_q;

  assign pix_a = in_beat.pixel_first[PW-1:0];
  assign pix_b = in_beat.pixel_second[PW-1:0];
  assign weight_inv = mbb_pkg::WeightOne - in_beat.weight;

  // A weight of 64 gives the first pixel exactly and 0 the second, so no bypass is needed.
  assign blend_sum = SW'(pix_a) * SW'(in_beat.weight) + SW'(pix_b) * SW'(weight_inv)
                   + SW'(mbb_pkg::BlendRound);
  assign pixel_next = blend_sum[PW+5:6];

  assign in_ready = !valid_q || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pixel_q <= pixel_next;
      last_q <= in_beat.last;
    end
  end

  assign out_valid = valid_q;
  assign out_pixel = mbb_pkg::PixPortBits'(pixel_q);
  assign out_last = last_q;

endmodule

FILE: rtl/masked_boundary_blend_unit.sv
// Top level of the masked boundary blend unit: position tracking, weight lookup and output.
//
// Usage: program the six registers through cfg_we, cfg_index and cfg_data while the unit
// is idle, then stream the pixel pairs of a region in raster order on the s_axis channel
// (pixel_first in tdata[11:0], pixel_second in tdata[23:12]). Each accepted beat yields
// exactly one m_axis beat carrying the blended pixel in tdata[11:0]; tlast marks the final
// pixel of the region, after which the row and column counters start over.
// An accepted beat passes the first register, holding the pixels with the mask weight looked
// up from the band position, then the second, holding the blended result. Throughput is one
// beat per cycle while m_axis_tready is high, as each stage hands its beat on in the same
// cycle that it takes the next. A new beat is accepted while a finished result waits,
// as long as the first stage is free. When the receiver stalls, up to two beats are held and
// s_axis_tready falls; nothing is lost or repeated. Reset clears both stages, the counters
// and the registers (region width and height 64, everything else zero).
module masked_boundary_blend_unit #(
  parameter int unsigned MAX_REGION = 64,
  parameter int unsigned PIXEL_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_first [11:0], pixel_second [23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pixel_out [11:0], zero padding [15:12]
  output logic        m_axis_tlast
);

  localparam int unsigned CW = $clog2(MAX_REGION);
  localparam int unsigned CMPW = ((CW > 7) ? CW : 7) + 1;

  logic                   split_vertical;
  logic [1:0]             mask_length_code;
  logic                   chroma_mask;
  logic [5:0]             blend_offset;
  logic [6:0]             region_width;
  logic [6:0]             region_height;
  logic [CW-1:0]          row_count;
  logic [CW-1:0]          col_count;
  logic [CW-1:0]          row_count_next;
  logic [CW-1:0]          col_count_next;

  logic [CMPW-1:0]        width_eff;
  logic [CMPW-1:0]        height_eff;
  logic [CMPW-1:0]        pos;
  logic [CMPW-1:0]        band_pos;
  logic [CMPW-1:0]        band_len;
  logic                   row_end;
  logic                   last_next;
  mbb_pkg::weight_t       weight_next;

  mbb_pkg::stage_t        s1_q;
  logic                   s1_valid;
  logic                   s1_ready;
  logic                   accept;
  logic [mbb_pkg::PixPortBits-1:0] pixel_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_vertical <= 1'b0;
      mask_length_code <= 2'd0;
      chroma_mask <= 1'b0;
      blend_offset <= 6'd0;
      region_width <= 7'd64;
      region_height <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        mbb_pkg::RegSplitVertical: split_vertical <= cfg_data[0];
        mbb_pkg::RegMaskLengthCode: mask_length_code <= cfg_data[1:0];
        mbb_pkg::RegChromaMask: chroma_mask <= cfg_data[0];
        mbb_pkg::RegBlendOffset: blend_offset <= cfg_data[5:0];
        mbb_pkg::RegRegionWidth: region_width <= cfg_data;
        mbb_pkg::RegRegionHeight: region_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_eff = (CMPW'(region_width) > CMPW'(MAX_REGION)) ?
                     CMPW'(MAX_REGION) : CMPW'(region_width);
  assign height_eff = (CMPW'(region_height) > CMPW'(MAX_REGION)) ?
                      CMPW'(MAX_REGION) : CMPW'(region_height);

  assign pos = split_vertical ? CMPW'(col_count) : CMPW'(row_count);
  assign band_pos = pos - CMPW'(blend_offset);
  assign band_len = (mask_length_code == mbb_pkg::LenCode8) ? CMPW'(8) :
                    (mask_length_code == mbb_pkg::LenCode16) ? CMPW'(16) : CMPW'(32);

  always_comb begin
    if (pos < CMPW'(blend_offset)) begin
      weight_next = mbb_pkg::WeightOne;
    end else if (band_pos < band_len) begin
      weight_next = mbb_pkg::mask_weight(mask_length_code, chroma_mask, band_pos[4:0]);
    end else begin
      weight_next = '0;
    end
  end

  assign row_end = (CMPW'(col_count) + CMPW'(1)) >= width_eff;
  assign last_next = row_end && ((CMPW'(row_count) + CMPW'(1)) >= height_eff);

  always_comb begin
    col_count_next = col_count + CW'(1);
    row_count_next = row_count;
    if (row_end) begin
      col_count_next = '0;
      row_count_next = last_next ? '0 : row_count + CW'(1);
    end
  end

  assign s_axis_tready = !s1_valid || s1_ready;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_q.pixel_first <= s_axis_tdata[11:0];
      s1_q.pixel_second <= s_axis_tdata[23:12];
      s1_q.weight <= weight_next;
      s1_q.last <= last_next;
    end
  end

  mbb_blend #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_beat   (s1_q),
    .in_ready  (s1_ready),
    .out_valid (m_axis_tvalid),
    .out_pixel (pixel_out),
    .out_last  (m_axis_tlast),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, pixel_out};

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && last_next |=> (row_count == '0) && (col_count == '0))
    else $error("counters did not restart after the last pixel of a region");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_q.weight <= mbb_pkg::WeightOne))
    else $error("mask weight above 64");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_axis_tvalid && !m_axis_tready |=> s1_valid && $stable(s1_q))
    else $error("first stage beat lost during output stall");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_axis_tready)
    else $error("input not ready with the first stage empty");
`endif

endmodule
